>>> rtl/vdi_pkg.sv
// Package for the vertex deduplication indexer: widths, hash constants,
// the queue entry type and the back-end state type. No dependencies.
package vdi_pkg;

    localparam int INDEX_BITS       = 16;
    localparam int KEY_W            = 3 * INDEX_BITS;
    localparam int HALF_W           = KEY_W / 2;
    localparam int VNUM_W           = 10;
    localparam int HASH_W           = 17;
    localparam int HASH_SHIFT       = 32;
    localparam int PROD_W           = HASH_SHIFT + HASH_W;
    localparam int EPOCH_W          = 4;
    localparam int MAX_VERTICES_DEF = 1024;
    localparam int BUCKETS_DEF      = 2048;

    localparam logic [EPOCH_W-1:0] EPOCH_MAX   = {EPOCH_W{1'b1}};
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_DEAD  = '0;

    localparam logic [63:0]         HASH_MULT = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [31:0]         MULT_LO   = HASH_MULT[31:0];
    localparam logic [HASH_W-1:0]   MULT_HI   = HASH_MULT[HASH_SHIFT +: HASH_W];

    // register indexes on the write port
    localparam logic CFG_TEXTURE = 1'b0;
    localparam logic CFG_NORMAL  = 1'b1;

    typedef struct packed {
        logic                  first;
        logic [INDEX_BITS-1:0] pos;
        logic [INDEX_BITS-1:0] tex;
        logic [INDEX_BITS-1:0] nrm;
        logic [HASH_W-1:0]     hash;
    } vdi_entry_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_READ,
        BK_CHECK
    } back_state_t;

endpackage

>>> rtl/vdi_if.sv
// Valid/ready channel interfaces for corners in and results out.
// Depends on vdi_pkg for field widths.
interface vdi_corner_if;
    logic                           valid;
    logic                           ready;
    logic                           first_of_model;
    logic [vdi_pkg::INDEX_BITS-1:0] position_index;
    logic [vdi_pkg::INDEX_BITS-1:0] texture_index;
    logic [vdi_pkg::INDEX_BITS-1:0] normal_index;

    modport source (output valid, first_of_model, position_index, texture_index,
                    normal_index, input ready);
    modport sink   (input valid, first_of_model, position_index, texture_index,
                    normal_index, output ready);
endinterface

interface vdi_result_if;
    logic                           valid;
    logic                           ready;
    logic [vdi_pkg::VNUM_W-1:0]     vertex_number;
    logic                           is_new;
    logic                           table_full;
    logic [vdi_pkg::INDEX_BITS-1:0] position_slot;
    logic [vdi_pkg::INDEX_BITS-1:0] texture_slot;
    logic [vdi_pkg::INDEX_BITS-1:0] normal_slot;

    modport source (output valid, vertex_number, is_new, table_full, position_slot,
                    texture_slot, normal_slot, input ready);
    modport sink   (input valid, vertex_number, is_new, table_full, position_slot,
                    texture_slot, normal_slot, output ready);
endinterface

>>> rtl/vdi_front.sv
// Front end: config registers, slot conversion, key forming and the
// split 64-bit hash multiply. Depends on vdi_pkg and vdi_corner_if.
module vdi_front
(
    input  logic                clk,
    input  logic                rst_n,
    vdi_corner_if.sink          corner,
    input  logic                wr_en,
    input  logic                wr_index,
    input  logic                wr_data,
    output logic                push,
    output vdi_pkg::vdi_entry_t push_data,
    input  logic                full
);

    localparam int IB = vdi_pkg::INDEX_BITS;
    localparam int HW = vdi_pkg::HALF_W;
    localparam int MW = HW + 32;

    logic tex_en_reg, nrm_en_reg;
    logic a_valid_reg, b_valid_reg;
    logic stall;

    logic          a_first_reg, b_first_reg;
    logic [IB-1:0] a_pos_reg, a_tex_reg, a_nrm_reg;
    logic [IB-1:0] b_pos_reg, b_tex_reg, b_nrm_reg;

    logic [vdi_pkg::KEY_W-1:0] key;
    logic [MW-1:0]             m0, m1, m2;
    logic [vdi_pkg::PROD_W-1:0]                    p0_reg, p0_next;
    logic [vdi_pkg::HASH_W-1:0]                    p1_reg, p1_next;
    logic [vdi_pkg::PROD_W-vdi_pkg::HALF_W-1:0]    p2_reg, p2_next;
    logic [vdi_pkg::PROD_W-1:0]                    sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tex_en_reg <= 1'b0;
            nrm_en_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                vdi_pkg::CFG_TEXTURE: tex_en_reg <= wr_data;
                vdi_pkg::CFG_NORMAL:  nrm_en_reg <= wr_data;
                default:              ;
            endcase
        end
    end

    assign stall        = b_valid_reg && full;
    assign corner.ready = !stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (!stall)
        begin
            a_valid_reg <= corner.valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    // stage A: 1-based to 0-based, disabled components forced to zero
    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            a_first_reg <= corner.first_of_model;
            a_pos_reg   <= corner.position_index - IB'(1);
            a_tex_reg   <= tex_en_reg ? corner.texture_index - IB'(1) : '0;
            a_nrm_reg   <= nrm_en_reg ? corner.normal_index - IB'(1) : '0;
        end
    end

    // stage B: partial products of key * HASH_MULT, kept only below bit PROD_W
    assign key = {a_nrm_reg, a_tex_reg, a_pos_reg};
    assign m0  = MW'(key[HW-1:0]) * MW'(vdi_pkg::MULT_LO);
    assign m1  = MW'(key[HW-1:0]) * MW'(vdi_pkg::MULT_HI);
    assign m2  = MW'(key[vdi_pkg::KEY_W-1:HW]) * MW'(vdi_pkg::MULT_LO);

    assign p0_next = m0[vdi_pkg::PROD_W-1:0];
    assign p1_next = m1[vdi_pkg::HASH_W-1:0];
    assign p2_next = m2[vdi_pkg::PROD_W-HW-1:0];

    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            p0_reg      <= p0_next;
            p1_reg      <= p1_next;
            p2_reg      <= p2_next;
            b_first_reg <= a_first_reg;
            b_pos_reg   <= a_pos_reg;
            b_tex_reg   <= a_tex_reg;
            b_nrm_reg   <= a_nrm_reg;
        end
    end

    assign sum = p0_reg
               + {p1_reg, {vdi_pkg::HASH_SHIFT{1'b0}}}
               + {p2_reg, {HW{1'b0}}};

    assign push            = b_valid_reg && !full;
    assign push_data.first = b_first_reg;
    assign push_data.pos   = b_pos_reg;
    assign push_data.tex   = b_tex_reg;
    assign push_data.nrm   = b_nrm_reg;
    assign push_data.hash  = sum[vdi_pkg::PROD_W-1:vdi_pkg::HASH_SHIFT];

endmodule

>>> rtl/vdi_queue.sv
// Two-entry queue that decouples the front end from the probe engine.
// Depends on vdi_pkg for the entry type.
module vdi_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  vdi_pkg::vdi_entry_t push_data,
    output logic                full,
    input  logic                pop,
    output logic                not_empty,
    output vdi_pkg::vdi_entry_t head
);

    vdi_pkg::vdi_entry_t slot_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full      = cnt_reg == 2'd2;
    assign not_empty = cnt_reg != 2'd0;
    assign head      = slot_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= !wp_reg;
            if (pop)
                rp_reg <= !rp_reg;
            case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + 2'd1;
                2'b01:   cnt_reg <= cnt_reg - 2'd1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wp_reg] <= push_data;
    end

endmodule

>>> rtl/vdi_back.sv
// Back end: hash table memory, linear probe sequencer, vertex counter and
// the result register. Depends on vdi_pkg and vdi_result_if.
module vdi_back
#(
    parameter int MAX_VERTICES = vdi_pkg::MAX_VERTICES_DEF,
    parameter int BUCKETS      = vdi_pkg::BUCKETS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                not_empty,
    input  vdi_pkg::vdi_entry_t head,
    output logic                pop,
    vdi_result_if.source        result
);

    localparam int AW    = $clog2(BUCKETS);
    localparam int NUM_W = $clog2(MAX_VERTICES);
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam int KW    = vdi_pkg::KEY_W;
    localparam int EW    = vdi_pkg::EPOCH_W;
    localparam int ENT_W = EW + KW + NUM_W;
    localparam int IB    = vdi_pkg::INDEX_BITS;

    // table memory: {epoch, key, number}
    logic [ENT_W-1:0] mem [BUCKETS];
    logic [ENT_W-1:0] rd_q;
    logic             rd_en, wr_en;
    logic [AW-1:0]    rd_addr, wr_addr;
    logic [ENT_W-1:0] wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_q <= mem[rd_addr];
    end

    vdi_pkg::back_state_t state_reg, state_next;
    logic [AW-1:0]        sweep_reg, sweep_next;
    logic                 resume_reg, resume_next;
    logic [EW-1:0]        epoch_reg, epoch_next;
    logic [CNT_W-1:0]     num_reg, num_next;
    logic [AW-1:0]        probe_reg, probe_next;
    logic [AW-1:0]        tries_reg, tries_next;
    vdi_pkg::vdi_entry_t  item_reg, item_next;

    logic                  ov_reg, ov_next;
    logic [NUM_W-1:0]      onum_reg, onum_next;
    logic                  onew_reg, onew_next;
    logic                  ofull_reg, ofull_next;
    logic [IB-1:0]         opos_reg, opos_next;
    logic [IB-1:0]         otex_reg, otex_next;
    logic [IB-1:0]         onrm_reg, onrm_next;

    logic [EW-1:0]    rd_epoch;
    logic [KW-1:0]    rd_key, key_cur;
    logic [NUM_W-1:0] rd_num;
    logic             live, hit, room, last_try, done, out_free, sweep_end;
    logic [31:0]      onum_wide;

    assign {rd_epoch, rd_key, rd_num} = rd_q;
    assign key_cur   = {item_reg.nrm, item_reg.tex, item_reg.pos};
    assign live      = rd_epoch == epoch_reg;
    assign hit       = live && (rd_key == key_cur);
    assign room      = num_reg < CNT_W'(MAX_VERTICES);
    assign last_try  = tries_reg == AW'(BUCKETS - 1);
    assign done      = hit || !live || last_try;
    assign out_free  = !ov_reg || result.ready;
    assign sweep_end = sweep_reg == AW'(BUCKETS - 1);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            vdi_pkg::BK_CLEAR:
                if (sweep_end)
                    state_next = resume_reg ? vdi_pkg::BK_READ : vdi_pkg::BK_IDLE;
            vdi_pkg::BK_IDLE:
                if (not_empty)
                    state_next = (head.first && epoch_reg == vdi_pkg::EPOCH_MAX)
                               ? vdi_pkg::BK_CLEAR : vdi_pkg::BK_READ;
            vdi_pkg::BK_READ:
                state_next = vdi_pkg::BK_CHECK;
            vdi_pkg::BK_CHECK:
                if (!done)
                    state_next = vdi_pkg::BK_READ;
                else if (out_free)
                    state_next = vdi_pkg::BK_IDLE;
            default:
                state_next = vdi_pkg::BK_IDLE;
        endcase
    end

    always_comb
    begin
        sweep_next  = sweep_reg;
        resume_next = resume_reg;
        epoch_next  = epoch_reg;
        num_next    = num_reg;
        probe_next  = probe_reg;
        tries_next  = tries_reg;
        item_next   = item_reg;
        ov_next     = ov_reg && !result.ready;
        onum_next   = onum_reg;
        onew_next   = onew_reg;
        ofull_next  = ofull_reg;
        opos_next   = opos_reg;
        otex_next   = otex_reg;
        onrm_next   = onrm_reg;
        pop         = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = probe_reg;
        wr_en       = 1'b0;
        wr_addr     = probe_reg;
        wr_data     = {epoch_reg, key_cur, num_reg[NUM_W-1:0]};
        case (state_reg)
            vdi_pkg::BK_CLEAR:
            begin
                // mark every bucket dead, then restart epochs
                wr_en      = 1'b1;
                wr_addr    = sweep_reg;
                wr_data    = {vdi_pkg::EPOCH_DEAD, {(KW + NUM_W){1'b0}}};
                sweep_next = sweep_reg + AW'(1);
                if (sweep_end)
                begin
                    epoch_next  = vdi_pkg::EPOCH_FIRST;
                    resume_next = 1'b0;
                end
            end
            vdi_pkg::BK_IDLE:
            begin
                if (not_empty)
                begin
                    pop        = 1'b1;
                    item_next  = head;
                    probe_next = head.hash[AW-1:0];
                    tries_next = '0;
                    if (head.first)
                    begin
                        num_next = '0;
                        if (epoch_reg == vdi_pkg::EPOCH_MAX)
                            resume_next = 1'b1;
                        else
                            epoch_next = epoch_reg + EW'(1);
                    end
                end
            end
            vdi_pkg::BK_READ:
                rd_en = 1'b1;
            vdi_pkg::BK_CHECK:
            begin
                if (!done)
                begin
                    probe_next = probe_reg + AW'(1);
                    tries_next = tries_reg + AW'(1);
                end
                else if (out_free)
                begin
                    ov_next    = 1'b1;
                    opos_next  = item_reg.pos;
                    otex_next  = item_reg.tex;
                    onrm_next  = item_reg.nrm;
                    onew_next  = 1'b0;
                    ofull_next = 1'b0;
                    if (hit)
                        onum_next = rd_num;
                    else if (!live && room)
                    begin
                        wr_en     = 1'b1;
                        onew_next = 1'b1;
                        onum_next = num_reg[NUM_W-1:0];
                        num_next  = num_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ofull_next = 1'b1;
                        onum_next  = '0;
                        opos_next  = '0;
                        otex_next  = '0;
                        onrm_next  = '0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= vdi_pkg::BK_CLEAR;
            sweep_reg  <= '0;
            resume_reg <= 1'b0;
            epoch_reg  <= vdi_pkg::EPOCH_FIRST;
            num_reg    <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            sweep_reg  <= sweep_next;
            resume_reg <= resume_next;
            epoch_reg  <= epoch_next;
            num_reg    <= num_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        probe_reg <= probe_next;
        tries_reg <= tries_next;
        item_reg  <= item_next;
        onum_reg  <= onum_next;
        onew_reg  <= onew_next;
        ofull_reg <= ofull_next;
        opos_reg  <= opos_next;
        otex_reg  <= otex_next;
        onrm_reg  <= onrm_next;
    end

    assign onum_wide            = 32'(onum_reg);
    assign result.valid         = ov_reg;
    assign result.vertex_number = onum_wide[vdi_pkg::VNUM_W-1:0];
    assign result.is_new        = onew_reg;
    assign result.table_full    = ofull_reg;
    assign result.position_slot = opos_reg;
    assign result.texture_slot  = otex_reg;
    assign result.normal_slot   = onrm_reg;

endmodule

>>> rtl/vertex_dedup_indexer.sv
// Vertex deduplication indexer, top level: front end, queue, probe engine.
// Path: a corner passes front stages A and B into the queue, then the probe engine
// pops it, reads and checks the table and registers the result; each extra probe
// repeats the read and the check. The engine takes one corner at a time (pop, read,
// compare, then write/result), set by the table's single read port, and it holds a
// finished check while the result is not taken. Reset: async low; clears control
// state, then a sweep kills all buckets; the sweep repeats on every 15th first_of_model (epoch wrap).
module vertex_dedup_indexer
#(
    parameter int MAX_VERTICES = vdi_pkg::MAX_VERTICES_DEF,
    // must be a power of two
    parameter int BUCKETS      = vdi_pkg::BUCKETS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    vdi_corner_if.sink   corner,
    vdi_result_if.source result,
    input  logic         wr_en,
    input  logic         wr_index,
    input  logic         wr_data
);

    // transfer from the front end into the queue
    logic                q_push, q_full, q_pop, q_not_empty;
    vdi_pkg::vdi_entry_t q_in, q_head;

    // form keys and hash; stall only when the queue is full
    vdi_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .corner    (corner),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full)
    );

    // hold classified corners while the probe engine is busy
    vdi_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    // probe the table, insert new keys, drive the result register
    vdi_back
    #(
        .MAX_VERTICES (MAX_VERTICES),
        .BUCKETS      (BUCKETS)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .not_empty (q_not_empty),
        .head      (q_head),
        .pop       (q_pop),
        .result    (result)
    );

endmodule

>>> rtl/vdi_checker.sv
// Port-level checker for the vertex deduplication indexer, bound to the top.
// Depends on vdi_pkg for field widths.
module vdi_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [vdi_pkg::VNUM_W-1:0]     vertex_number,
    input logic                           is_new,
    input logic                           table_full,
    input logic [vdi_pkg::INDEX_BITS-1:0] position_slot,
    input logic [vdi_pkg::INDEX_BITS-1:0] texture_slot,
    input logic [vdi_pkg::INDEX_BITS-1:0] normal_slot
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && table_full |-> vertex_number == '0 && !is_new
            && position_slot == '0 && texture_slot == '0 && normal_slot == '0)
        else $error("full result carries nonzero fields");

    a_new_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_new |-> !table_full)
        else $error("new vertex flagged full");

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result valid during reset");

endmodule

bind vertex_dedup_indexer vdi_checker u_vdi_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .vertex_number (result.vertex_number),
    .is_new        (result.is_new),
    .table_full    (result.table_full),
    .position_slot (result.position_slot),
    .texture_slot  (result.texture_slot),
    .normal_slot   (result.normal_slot)
);

>>> dv/tb_vertex_dedup_indexer.sv
`timescale 1ns / 100ps
// Self-checking testbench for the vertex deduplication indexer.
// Depends on vdi_pkg and the vdi_corner_if / vdi_result_if interfaces in rtl/.
module tb_vertex_dedup_indexer;

    localparam int NUM_BUCKETS = vdi_pkg::BUCKETS_DEF;
    localparam int NUM_VERTS   = vdi_pkg::MAX_VERTICES_DEF;
    localparam int WATCH_LIMIT = 20000;
    localparam int HOME_W      = $clog2(NUM_BUCKETS);
    localparam int IB          = vdi_pkg::INDEX_BITS;

    typedef struct packed {
        logic          first;
        logic [IB-1:0] pos;
        logic [IB-1:0] tex;
        logic [IB-1:0] nrm;
    } corner_t;

    typedef struct packed {
        logic [vdi_pkg::VNUM_W-1:0] vnum;
        logic                       is_new;
        logic                       full;
        logic [IB-1:0]              pos;
        logic [IB-1:0]              tex;
        logic [IB-1:0]              nrm;
    } lookup_t;

    logic clk;
    logic rst_n;
    logic wr_en;
    logic wr_index;
    logic wr_data;

    vdi_corner_if corner ();
    vdi_result_if result ();

    vertex_dedup_indexer uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .corner   (corner.sink),
        .result   (result.source),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    // Shadow of the hash table and the vertex counter.
    logic [vdi_pkg::KEY_W-1:0]  shadow_key [NUM_BUCKETS];
    logic [vdi_pkg::VNUM_W-1:0] shadow_num [NUM_BUCKETS];
    logic                       shadow_valid [NUM_BUCKETS];
    int unsigned                shadow_next;
    logic                       tex_on;
    logic                       nrm_on;

    corner_t corner_queue [$];
    lookup_t lookup_queue [$];

    int send_idle;     // percent of cycles the sender holds off
    int recv_idle;     // percent of cycles the receiver stalls
    bit hold_sender;
    bit in_taken;      // input transfer seen at the last rising edge
    int errors;
    int n_sent;
    int n_recv;
    int n_full;
    int n_new;
    int watch;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic logic [HOME_W-1:0] home_of(logic [vdi_pkg::KEY_W-1:0] key);
        logic [63:0] prod;
        prod = 64'(key) * 64'h9E37_79B9_7F4A_7C15;
        return prod[32 +: HOME_W];
    endfunction

    // Compute the expected lookup result and advance the shadow table.
    function automatic lookup_t dedup_lookup(corner_t c);
        lookup_t r;
        logic [IB-1:0] p, t, n;
        logic [vdi_pkg::KEY_W-1:0] key;
        int b;
        bit found, empty;
        found = 0;
        empty = 0;
        if (c.first)
        begin
            foreach (shadow_valid[i]) shadow_valid[i] = 1'b0;
            shadow_next = 0;
        end
        p = c.pos - IB'(1);
        t = tex_on ? c.tex - IB'(1) : '0;
        n = nrm_on ? c.nrm - IB'(1) : '0;
        key = {n, t, p};
        b = int'(home_of(key));
        for (int i = 0; i < NUM_BUCKETS; i++)
        begin
            if (!shadow_valid[b])
            begin
                empty = 1;
                break;
            end
            if (shadow_key[b] == key)
            begin
                found = 1;
                break;
            end
            b = (b + 1) % NUM_BUCKETS;
        end
        r = '0;
        if (found)
            r.vnum = shadow_num[b];
        else if (empty && shadow_next < NUM_VERTS)
        begin
            shadow_valid[b] = 1'b1;
            shadow_key[b] = key;
            shadow_num[b] = shadow_next[vdi_pkg::VNUM_W-1:0];
            r.vnum = shadow_next[vdi_pkg::VNUM_W-1:0];
            r.is_new = 1'b1;
            shadow_next++;
        end
        else
        begin
            r.full = 1'b1;
            return r;
        end
        r.pos = p;
        r.tex = t;
        r.nrm = n;
        return r;
    endfunction

    // Driver: change inputs on the falling edge; hold the transfer until accepted.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_taken)
                void'(corner_queue.pop_front());
            if (corner.valid && !in_taken)
                ;   // hold the pending transfer
            else if (corner_queue.size() > 0 && !hold_sender
                     && $urandom_range(99) >= send_idle)
            begin
                corner.valid          <= 1'b1;
                corner.first_of_model <= corner_queue[0].first;
                corner.position_index <= corner_queue[0].pos;
                corner.texture_index  <= corner_queue[0].tex;
                corner.normal_index   <= corner_queue[0].nrm;
            end
            else
                corner.valid <= 1'b0;
            result.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Monitor: sample at the rising edge, predict on acceptance, check results.
    always @(posedge clk)
    begin
        lookup_t got, want;
        if (rst_n)
        begin
            in_taken <= corner.valid && corner.ready;
            if ((corner.valid && corner.ready) || (result.valid && result.ready))
                watch <= 0;
            else
                watch <= watch + 1;
            if (corner.valid && corner.ready)
            begin
                lookup_queue.insert(lookup_queue.size(), dedup_lookup({corner.first_of_model,
                    corner.position_index, corner.texture_index, corner.normal_index}));
                n_sent <= n_sent + 1;
            end
            if (result.valid && result.ready)
            begin
                n_recv <= n_recv + 1;
                got = {result.vertex_number, result.is_new, result.table_full,
                       result.position_slot, result.texture_slot, result.normal_slot};
                if (lookup_queue.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, got);
                    errors <= errors + 1;
                end
                else
                begin
                    want = lookup_queue.pop_front();
                    if (got.full) n_full <= n_full + 1;
                    if (got.is_new) n_new <= n_new + 1;
                    if (got !== want)
                    begin
                        $display("%0t: mismatch vnum/new/full/pos/tex/nrm", $time);
                        $display("  expected %0d %b %b %h %h %h", want.vnum, want.is_new,
                                 want.full, want.pos, want.tex, want.nrm);
                        $display("  actual   %0d %b %b %h %h %h", got.vnum, got.is_new,
                                 got.full, got.pos, got.tex, got.nrm);
                        errors <= errors + 1;
                    end
                end
            end
            if (watch >= WATCH_LIMIT)
            begin
                $display("%0t: watchdog expired, %0d results outstanding",
                         $time, lookup_queue.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic add_corner(bit first, logic [15:0] p, logic [15:0] t, logic [15:0] n);
        corner_t c;
        c = {first, p, t, n};
        corner_queue.insert(corner_queue.size(), c);
    endtask

    // Let everything drain, then pad past the probe engine's latency.
    task automatic drain();
        while (corner_queue.size() > 0 || corner.valid || lookup_queue.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Write one register while the block is idle.
    task automatic write_reg(logic idx, logic val);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        @(negedge clk);
        wr_en <= 1'b0;
        if (idx == vdi_pkg::CFG_TEXTURE) tex_on = val;
        else nrm_on = val;
    endtask

    // Random corners reusing a small index pool so keys repeat often.
    task automatic random_mesh(int count, int pool);
        for (int i = 0; i < count; i++)
        begin
            int r;
            r = $urandom_range(99);
            if (r < 3)
                add_corner(1'b1, 16'($urandom), 16'($urandom), 16'($urandom));
            else if (r < 10)
                add_corner(1'b0, 16'($urandom), 16'($urandom), 16'($urandom));
            else
                add_corner(1'b0, 16'($urandom_range(pool)), 16'($urandom_range(pool)),
                           16'($urandom_range(pool)));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        wr_en = 1'b0;
        wr_index = vdi_pkg::CFG_TEXTURE;
        wr_data = 1'b0;
        corner.valid = 1'b0;
        corner.first_of_model = 1'b0;
        corner.position_index = '0;
        corner.texture_index = '0;
        corner.normal_index = '0;
        result.ready = 1'b0;
        hold_sender = 0;
        in_taken = 0;
        tex_on = 1'b0;
        nrm_on = 1'b0;
        errors = 0;
        n_sent = 0;
        n_recv = 0;
        n_full = 0;
        n_new = 0;
        watch = 0;
        shadow_next = 0;
        foreach (shadow_valid[i]) shadow_valid[i] = 1'b0;
        send_idle = 21;
        recv_idle = 78;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset defaults, extremes, index zero wrap, repeats.
        add_corner(1'b1, 16'd1, 16'd5, 16'd9);
        add_corner(1'b0, 16'd1, 16'd7, 16'd3);
        add_corner(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_corner(1'b0, 16'd0, 16'd0, 16'd0);
        add_corner(1'b0, 16'd0, 16'd1, 16'd1);
        add_corner(1'b0, 16'hAAAA, 16'h5555, 16'h0001);
        add_corner(1'b0, 16'h5555, 16'hAAAA, 16'hFFFF);
        drain();
        write_reg(vdi_pkg::CFG_TEXTURE, 1'b1);
        write_reg(vdi_pkg::CFG_NORMAL, 1'b1);
        add_corner(1'b0, 16'd1, 16'd5, 16'd9);
        add_corner(1'b0, 16'd1, 16'd5, 16'd9);
        add_corner(1'b0, 16'd1, 16'd5, 16'd10);
        add_corner(1'b0, 16'd0, 16'd0, 16'd0);
        add_corner(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_corner(1'b0, 16'hAAAA, 16'h5555, 16'hAAAA);
        add_corner(1'b0, 16'h5555, 16'hAAAA, 16'h5555);
        add_corner(1'b1, 16'd1, 16'd5, 16'd9);
        add_corner(1'b0, 16'd1, 16'd5, 16'd9);
        drain();

        // Fill the table past MAX_VERTICES: full flags, then known keys still hit.
        write_reg(vdi_pkg::CFG_NORMAL, 1'b0);
        add_corner(1'b1, 16'd1, 16'd1, 16'd1);
        for (int i = 2; i <= NUM_VERTS + 8; i++)
            add_corner(1'b0, i[15:0], 16'd1, 16'd1);
        for (int i = 0; i < 8; i++)
            add_corner(1'b0, 16'($urandom_range(NUM_VERTS, 1)), 16'd1, 16'($urandom));
        drain();

        // Random phases across settings and idling patterns.
        send_idle = 21;
        recv_idle = 78;
        write_reg(vdi_pkg::CFG_TEXTURE, 1'b0);
        random_mesh(120, 40);
        // Pause the sender until every result is back.
        hold_sender = 1;
        while (lookup_queue.size() > 0 || corner.valid) @(posedge clk);
        hold_sender = 0;
        random_mesh(50, 300);
        drain();
        send_idle = 78;
        recv_idle = 21;
        write_reg(vdi_pkg::CFG_NORMAL, 1'b1);
        random_mesh(130, 60);
        drain();
        write_reg(vdi_pkg::CFG_TEXTURE, 1'b1);
        random_mesh(120, 30);
        drain();
        send_idle = 0;
        recv_idle = 0;
        write_reg(vdi_pkg::CFG_NORMAL, 1'b0);
        random_mesh(110, 100);
        drain();
        write_reg(vdi_pkg::CFG_TEXTURE, 1'b0);
        write_reg(vdi_pkg::CFG_NORMAL, 1'b1);
        random_mesh(110, 500);
        drain();

        $display("Covered %0d corners, %0d results (%0d new, %0d table-full),",
                 n_sent, n_recv, n_new, n_full);
        $display("all four key-enable settings and three idling patterns.");
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
